>>> rtl/rfst_pkg.sv
`default_nettype none

package rfst_pkg;

  localparam int unsigned LEAVES_DEF      = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned RANGE_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OP_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FOLD  = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_MIN = 3'd1,
    OP_MAX = 3'd2,
    OP_AND = 3'd3,
    OP_OR  = 3'd4,
    OP_XOR = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_SELECT = 1'b0,
    REG_IDENTITY  = 1'b1
  } reg_e;

  typedef logic [3:0] upc_t;

  localparam upc_t U_CLEAR  = 4'd0;
  localparam upc_t U_IDLE   = 4'd1;
  localparam upc_t U_WLEAF  = 4'd2;
  localparam upc_t U_WREAD  = 4'd3;
  localparam upc_t U_WUPD   = 4'd4;
  localparam upc_t U_RREAD  = 4'd5;
  localparam upc_t U_REMIT  = 4'd6;
  localparam upc_t U_IEMIT  = 4'd7;
  localparam upc_t U_FREAD  = 4'd8;
  localparam upc_t U_FACC   = 4'd9;
  localparam upc_t U_FEMIT  = 4'd10;
  localparam upc_t U_XLEAF  = 4'd11;
  localparam upc_t U_XINNER = 4'd12;
  localparam upc_t U_XREAD  = 4'd13;
  localparam upc_t U_XUPD   = 4'd14;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_PTR_NOT_LAST,
    C_PTR_NOT_ONE,
    C_LO_LT_HI,
    C_OUT_BUSY,
    C_DISPATCH
  } cond_e;

  typedef enum logic [2:0] {
    P_HOLD,
    P_INC,
    P_DEC,
    P_HALF,
    P_INNER
  } ptr_op_e;

  typedef enum logic [1:0] {
    W_NONE,
    W_ZERO,
    W_VAL,
    W_COMB
  } wsrc_e;

  typedef enum logic [1:0] {
    R_NONE,
    R_PTR,
    R_CHILD,
    R_RANGE
  } rsel_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_RDA,
    RES_ID,
    RES_FOLD
  } res_e;

  typedef struct packed {
    cond_e   cond;
    upc_t    next_t;
    upc_t    next_f;
    ptr_op_e ptr_op;
    wsrc_e   wsrc;
    rsel_e   rsel;
    logic    fold_adv;
    logic    fold_acc;
    res_e    res;
    logic    take;
  } ucode_t;

  function automatic ucode_t uw(cond_e c, upc_t t, upc_t f, ptr_op_e p, wsrc_e w,
                                rsel_e r, logic adv, logic acc, res_e res, logic take);
    ucode_t word;
    word.cond     = c;
    word.next_t   = t;
    word.next_f   = f;
    word.ptr_op   = p;
    word.wsrc     = w;
    word.rsel     = r;
    word.fold_adv = adv;
    word.fold_acc = acc;
    word.res      = res;
    word.take     = take;
    return word;
  endfunction

  // control store: condition true takes next_t (the dispatch target under C_DISPATCH), false takes next_f
  function automatic ucode_t ucode_rom(upc_t upc);
    ucode_t word;
    unique case (upc)
      U_CLEAR:  word = uw(C_PTR_NOT_LAST, U_CLEAR, U_IDLE, P_INC, W_ZERO, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_IDLE:   word = uw(C_DISPATCH, U_IDLE, U_IDLE, P_HOLD, W_NONE, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b1);
      U_WLEAF:  word = uw(C_ALWAYS, U_WREAD, U_WREAD, P_HALF, W_VAL, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_WREAD:  word = uw(C_ALWAYS, U_WUPD, U_WUPD, P_HOLD, W_NONE, R_CHILD,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_WUPD:   word = uw(C_PTR_NOT_ONE, U_WREAD, U_IDLE, P_HALF, W_COMB, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_RREAD:  word = uw(C_ALWAYS, U_REMIT, U_REMIT, P_HOLD, W_NONE, R_PTR,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_REMIT:  word = uw(C_OUT_BUSY, U_REMIT, U_IDLE, P_HOLD, W_NONE, R_NONE,
                          1'b0, 1'b0, RES_RDA, 1'b0);
      U_IEMIT:  word = uw(C_OUT_BUSY, U_IEMIT, U_IDLE, P_HOLD, W_NONE, R_NONE,
                          1'b0, 1'b0, RES_ID, 1'b0);
      U_FREAD:  word = uw(C_ALWAYS, U_FACC, U_FACC, P_HOLD, W_NONE, R_RANGE,
                          1'b1, 1'b0, RES_NONE, 1'b0);
      U_FACC:   word = uw(C_LO_LT_HI, U_FREAD, U_FEMIT, P_HOLD, W_NONE, R_NONE,
                          1'b0, 1'b1, RES_NONE, 1'b0);
      U_FEMIT:  word = uw(C_OUT_BUSY, U_FEMIT, U_IDLE, P_HOLD, W_NONE, R_NONE,
                          1'b0, 1'b0, RES_FOLD, 1'b0);
      U_XLEAF:  word = uw(C_PTR_NOT_LAST, U_XLEAF, U_XINNER, P_INC, W_VAL, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_XINNER: word = uw(C_ALWAYS, U_XREAD, U_XREAD, P_INNER, W_NONE, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_XREAD:  word = uw(C_ALWAYS, U_XUPD, U_XUPD, P_HOLD, W_NONE, R_CHILD,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      U_XUPD:   word = uw(C_PTR_NOT_ONE, U_XREAD, U_IDLE, P_DEC, W_COMB, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
      default:  word = uw(C_ALWAYS, U_IDLE, U_IDLE, P_HOLD, W_NONE, R_NONE,
                          1'b0, 1'b0, RES_NONE, 1'b0);
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rfst_in_if.sv
`default_nettype none

interface rfst_in_if;
  logic                             valid;
  logic                             ready;
  logic [rfst_pkg::CMD_W-1:0]       command;
  logic [rfst_pkg::IDX_W-1:0]       leaf_index;
  logic [rfst_pkg::DATA_W-1:0]      write_value;
  logic [rfst_pkg::RANGE_W-1:0]     range_start;
  logic [rfst_pkg::RANGE_W-1:0]     range_end;

  modport source (
    output valid, command, leaf_index, write_value, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, command, leaf_index, write_value, range_start, range_end,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rfst_out_if.sv
`default_nettype none

interface rfst_out_if;
  logic                        valid;
  logic                        ready;
  logic [rfst_pkg::DATA_W-1:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

`default_nettype wire

>>> rtl/range_fold_segment_tree.sv
// channel   dir  handshake      word
// in_i      in   valid/ready    command, leaf_index, write_value, range_start, range_end
// out_o     out  valid/ready    result_value
// cfg       in   cfg_we_i       cfg_index_i, cfg_wdata_i (0 op_select, 1 identity_value)
//
// Each word runs on the single write port and registered reads of the node RAM: a read
// emits a leaf, a write recombines every ancestor up to the root, a fold walks the tree
// level by level, a fill writes every leaf and rebuilds the inner nodes. One word is in
// work at a time; the result register frees the next. After reset a clearing pass zeroes
// the nodes, in_i held off. A full, untaken result stalls the sequencer at emit steps only.
`default_nettype none

module range_fold_segment_tree #(
  parameter int unsigned LEAVES      = rfst_pkg::LEAVES_DEF,
  parameter int unsigned VALUE_WIDTH = rfst_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rfst_in_if.sink                              in_i,
  rfst_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rfst_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(NODES);
  localparam int unsigned PW    = $clog2(NODES + 1);

  typedef logic [VALUE_WIDTH-1:0] val_t;

  function automatic val_t fold_op(logic [rfst_pkg::OP_W-1:0] op, val_t a, val_t b);
    unique case (op)
      rfst_pkg::OP_MIN: return (a < b) ? a : b;
      rfst_pkg::OP_MAX: return (a > b) ? a : b;
      rfst_pkg::OP_AND: return a & b;
      rfst_pkg::OP_OR:  return a | b;
      rfst_pkg::OP_XOR: return a ^ b;
      default:          return a + b;
    endcase
  endfunction

  rfst_pkg::ucode_t uw_c;

  rfst_pkg::upc_t upc_q, upc_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic           out_valid_q, out_valid_d;
  logic [rfst_pkg::OP_W-1:0] op_q;
  val_t           ident_q;

  val_t           val_q;
  logic [PW-1:0]  lo_q, hi_q;
  logic           lo_odd_q, hi_odd_q;
  val_t           left_q, right_q;
  val_t           result_q;

  logic           in_fire, out_busy, cond_c, res_load;
  rfst_pkg::upc_t dispatch_c;
  logic [31:0]    idx_w, rs_w, re_w, lo_sat, hi_sat;
  logic           idx_ok, range_ok;
  logic [63:0]    wv64, cfg64, res64;
  val_t           in_val, cfg_val;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
  val_t           ram_wdata, rd_a, rd_b;
  logic [PW-1:0]  hi_dec;
  val_t           child_comb, fold_res, res_c;

  assign uw_c     = rfst_pkg::ucode_rom(upc_q);
  assign in_i.ready = uw_c.take;
  assign in_fire  = in_i.valid & in_i.ready;
  assign out_busy = out_valid_q & ~out_o.ready;

  assign idx_w    = 32'(in_i.leaf_index);
  assign rs_w     = 32'(in_i.range_start);
  assign re_w     = 32'(in_i.range_end);
  assign idx_ok   = idx_w < 32'(LEAVES);
  assign lo_sat   = (rs_w > 32'(LEAVES)) ? 32'(LEAVES) : rs_w;
  assign hi_sat   = (re_w > 32'(LEAVES)) ? 32'(LEAVES) : re_w;
  assign range_ok = lo_sat < hi_sat;

  assign wv64    = 64'(in_i.write_value);
  assign in_val  = wv64[VALUE_WIDTH-1:0];
  assign cfg64   = 64'(cfg_wdata_i);
  assign cfg_val = cfg64[VALUE_WIDTH-1:0];

  always_comb begin
    unique case (in_i.command)
      rfst_pkg::CMD_WRITE: dispatch_c = idx_ok ? rfst_pkg::U_WLEAF : rfst_pkg::U_IDLE;
      rfst_pkg::CMD_READ:  dispatch_c = idx_ok ? rfst_pkg::U_RREAD : rfst_pkg::U_IEMIT;
      rfst_pkg::CMD_FOLD:  dispatch_c = range_ok ? rfst_pkg::U_FREAD : rfst_pkg::U_IEMIT;
      rfst_pkg::CMD_FILL:  dispatch_c = rfst_pkg::U_XLEAF;
    endcase
  end

  always_comb begin
    unique case (uw_c.cond)
      rfst_pkg::C_ALWAYS:       cond_c = 1'b1;
      rfst_pkg::C_PTR_NOT_LAST: cond_c = ptr_q != AW'(NODES - 1);
      rfst_pkg::C_PTR_NOT_ONE:  cond_c = ptr_q != AW'(1);
      rfst_pkg::C_LO_LT_HI:     cond_c = lo_q < hi_q;
      rfst_pkg::C_OUT_BUSY:     cond_c = out_busy;
      rfst_pkg::C_DISPATCH:     cond_c = in_fire;
      default:                  cond_c = 1'b1;
    endcase
  end

  always_comb begin
    if (!cond_c) begin
      upc_d = uw_c.next_f;
    end else if (uw_c.cond == rfst_pkg::C_DISPATCH) begin
      upc_d = dispatch_c;
    end else begin
      upc_d = uw_c.next_t;
    end
  end

  always_comb begin
    if (in_fire) begin
      ptr_d = (in_i.command == rfst_pkg::CMD_FILL) ? AW'(LEAVES) : AW'(idx_w + 32'(LEAVES));
    end else begin
      unique case (uw_c.ptr_op)
        rfst_pkg::P_HOLD:  ptr_d = ptr_q;
        rfst_pkg::P_INC:   ptr_d = ptr_q + AW'(1);
        rfst_pkg::P_DEC:   ptr_d = ptr_q - AW'(1);
        rfst_pkg::P_HALF:  ptr_d = ptr_q >> 1;
        rfst_pkg::P_INNER: ptr_d = AW'(LEAVES - 1);
        default:           ptr_d = ptr_q;
      endcase
    end
  end

  assign child_comb = fold_op(op_q, rd_a, rd_b);
  assign fold_res   = fold_op(op_q, left_q, right_q);
  assign hi_dec     = hi_q - PW'(1);

  always_comb begin
    ram_we    = uw_c.wsrc != rfst_pkg::W_NONE;
    ram_waddr = ptr_q;
    unique case (uw_c.wsrc)
      rfst_pkg::W_VAL:  ram_wdata = val_q;
      rfst_pkg::W_COMB: ram_wdata = child_comb;
      default:          ram_wdata = '0;
    endcase
  end

  always_comb begin
    ram_re = uw_c.rsel != rfst_pkg::R_NONE;
    unique case (uw_c.rsel)
      rfst_pkg::R_CHILD: begin
        ram_raddr_a = {ptr_q[AW-2:0], 1'b0};
        ram_raddr_b = {ptr_q[AW-2:0], 1'b1};
      end
      rfst_pkg::R_RANGE: begin
        ram_raddr_a = lo_q[AW-1:0];
        ram_raddr_b = hi_dec[AW-1:0];
      end
      default: begin
        ram_raddr_a = ptr_q;
        ram_raddr_b = ptr_q;
      end
    endcase
  end

  rfst_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (NODES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    unique case (uw_c.res)
      rfst_pkg::RES_RDA:  res_c = rd_a;
      rfst_pkg::RES_FOLD: res_c = fold_res;
      default:            res_c = ident_q;
    endcase
  end

  assign res_load    = (uw_c.res != rfst_pkg::RES_NONE) & ~out_busy;
  assign out_valid_d = res_load | out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= rfst_pkg::U_CLEAR;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= rfst_pkg::OP_ADD;
      ident_q     <= '0;
    end else begin
      upc_q       <= upc_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rfst_pkg::REG_OP_SELECT: op_q    <= cfg_wdata_i[rfst_pkg::OP_W-1:0];
          rfst_pkg::REG_IDENTITY:  ident_q <= cfg_val;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      val_q   <= in_val;
      lo_q    <= PW'(lo_sat + 32'(LEAVES));
      hi_q    <= PW'(hi_sat + 32'(LEAVES));
      left_q  <= ident_q;
      right_q <= ident_q;
    end
    if (uw_c.fold_adv) begin
      lo_odd_q <= lo_q[0];
      hi_odd_q <= hi_q[0];
      lo_q     <= (lo_q + PW'(lo_q[0])) >> 1;
      hi_q     <= (hi_q - PW'(hi_q[0])) >> 1;
    end
    if (uw_c.fold_acc) begin
      if (lo_odd_q) begin
        left_q <= fold_op(op_q, left_q, rd_a);
      end
      if (hi_odd_q) begin
        right_q <= fold_op(op_q, rd_b, right_q);
      end
    end
    if (res_load) begin
      result_q <= res_c;
    end
  end

  assign res64              = 64'(result_q);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = res64[rfst_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

>>> rtl/rfst_ram.sv
`default_nettype none

module rfst_ram #(
  parameter int unsigned WIDTH = rfst_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DEPTH = 2 * rfst_pkg::LEAVES_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire
